// File: hw/rtl/cge_pkg.sv
// shared types, constants and register codes of the glyph expander
package cge_pkg;

	localparam int MAX_GLYPH_WIDTH  = 16;
	localparam int MAX_GLYPH_HEIGHT = 32;
	localparam int NUM_CHARS        = 256;

	localparam int ROW_BITS_W = 16;
	localparam int CHAR_W     = 8;
	localparam int ROW_W      = $clog2(MAX_GLYPH_HEIGHT);
	localparam int HGT_W      = $clog2(MAX_GLYPH_HEIGHT + 1);
	localparam int SPAN_W     = $clog2(MAX_GLYPH_WIDTH + 1);
	localparam int SX_W       = $clog2(ROW_BITS_W);
	localparam int FONT_DEPTH = NUM_CHARS * MAX_GLYPH_HEIGHT;
	localparam int FONT_AW    = $clog2(FONT_DEPTH);
	localparam int CFG_DW     = 16;
	localparam int CFG_IW     = 3;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_DRAW = 1'b1;

	typedef enum logic [CFG_IW-1:0] {
		REG_GLYPH_WIDTH  = 3'd0,
		REG_GLYPH_HEIGHT = 3'd1,
		REG_BYTES_PER_PX = 3'd2,
		REG_LINE_PITCH   = 3'd3,
		REG_CLIP_LEFT    = 3'd4,
		REG_CLIP_TOP     = 3'd5,
		REG_CLIP_RIGHT   = 3'd6,
		REG_CLIP_BOTTOM  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [4:0]  glyph_width;
		logic [5:0]  glyph_height;
		logic [2:0]  bytes_per_pixel;
		logic [15:0] line_pitch;
		logic [11:0] clip_left;
		logic [11:0] clip_top;
		logic [11:0] clip_right;
		logic [11:0] clip_bottom;
	} cfg_t;

	typedef struct packed {
		logic                  wr_en;
		logic [FONT_AW-1:0]    wr_addr;
		logic [ROW_BITS_W-1:0] wr_data;
		logic                  rd_en;
		logic [FONT_AW-1:0]    rd_addr;
	} font_req_t;

endpackage

// File: hw/rtl/cge_ifs.sv
// request and result channel interfaces

interface cge_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [7:0]  char_code;
	logic [4:0]  row_index;
	logic [15:0] row_bits;
	logic signed [12:0] pos_x;
	logic signed [12:0] pos_y;
	logic [31:0] pixel_color;

	modport source (output valid, req_type, char_code, row_index, row_bits, pos_x, pos_y,
		pixel_color, input ready);
	modport sink (input valid, req_type, char_code, row_index, row_bits, pos_x, pos_y,
		pixel_color, output ready);
endinterface

interface cge_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] row_address;
	logic [15:0] pixel_mask;
	logic [4:0]  span_length;
	logic [31:0] out_color;
	logic        last_row;

	modport source (output valid, row_address, pixel_mask, span_length, out_color, last_row,
		input ready);
	modport sink (input valid, row_address, pixel_mask, span_length, out_color, last_row,
		output ready);
endinterface

// File: hw/rtl/clipped_glyph_expander.sv
// top level: configuration registers, font memory and draw sequencer
//
// Use: requests arrive on req (valid/ready beats). A load beat (req_type 0)
// writes one 16-bit glyph row into the font memory. A draw beat (req_type 1)
// clips the glyph cell to the clip rectangle and produces one beat on res
// per visible row, top to bottom, the final one flagged by last_row. A draw
// with nothing visible produces no beat.
// The first row beat follows the clip step, two multiply-add steps for the
// start address and the font read.
// Throughput: a draw holds the request side until all its rows are read,
// one row per cycle while res is ready, set by the single font read port
// and the shared multiply-add that steps the address by the line pitch.
// Loads run at one per cycle while no draw is in progress.
// Config: cfg_we writes cfg_data into register cfg_index; write only while
// no draw is in progress. Reset returns the registers to their defaults;
// font contents are kept undefined until loaded.
// Stall: res holds its beat while ready is low and the row sequencer waits.
module clipped_glyph_expander
	import cge_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	cge_req_if.sink           req,
	cge_res_if.source         res
);

	cfg_t                  cfg_q;
	font_req_t             font_req;
	logic [ROW_BITS_W-1:0] rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glyph_width     <= 5'd8;
			cfg_q.glyph_height    <= 6'd16;
			cfg_q.bytes_per_pixel <= 3'd4;
			cfg_q.line_pitch      <= 16'd2560;
			cfg_q.clip_left       <= 12'd0;
			cfg_q.clip_top        <= 12'd0;
			cfg_q.clip_right      <= 12'd639;
			cfg_q.clip_bottom     <= 12'd479;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GLYPH_WIDTH:  cfg_q.glyph_width     <= cfg_data[4:0];
				REG_GLYPH_HEIGHT: cfg_q.glyph_height    <= cfg_data[5:0];
				REG_BYTES_PER_PX: cfg_q.bytes_per_pixel <= cfg_data[2:0];
				REG_LINE_PITCH:   cfg_q.line_pitch      <= cfg_data[15:0];
				REG_CLIP_LEFT:    cfg_q.clip_left       <= cfg_data[11:0];
				REG_CLIP_TOP:     cfg_q.clip_top        <= cfg_data[11:0];
				REG_CLIP_RIGHT:   cfg_q.clip_right      <= cfg_data[11:0];
				REG_CLIP_BOTTOM:  cfg_q.clip_bottom     <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	cge_font_mem u_font_mem (
		.clk      (clk),
		.font_req (font_req),
		.rd_data  (rd_data)
	);

	cge_row_seq u_row_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.req      (req),
		.res      (res),
		.font_req (font_req),
		.rd_data  (rd_data)
	);

endmodule

// File: hw/rtl/cge_font_mem.sv
// font row memory, one write port and one registered read port
module cge_font_mem
	import cge_pkg::*;
(
	input  logic                  clk,
	input  font_req_t             font_req,
	output logic [ROW_BITS_W-1:0] rd_data
);

	logic [ROW_BITS_W-1:0] mem_q [FONT_DEPTH];

	always_ff @(posedge clk) begin
		if (font_req.wr_en) begin
			mem_q[font_req.wr_addr] <= font_req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (font_req.rd_en) begin
			rd_data <= mem_q[font_req.rd_addr];
		end
	end

endmodule

// File: hw/rtl/cge_row_seq.sv
// draw sequencer: clipping, shared multiply-add for addresses, row issue and result register
module cge_row_seq
	import cge_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	cge_req_if.sink               req,
	cge_res_if.source             res,
	output font_req_t             font_req,
	input  logic [ROW_BITS_W-1:0] rd_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLIP,
		ST_MULX,
		ST_MULY,
		ST_ROWS
	} state_t;

	state_t state_q;

	// latched draw request
	logic [CHAR_W-1:0]  ch_q;
	logic signed [12:0] pos_x_q;
	logic signed [12:0] pos_y_q;
	logic [31:0]        color_q;

	// clipped geometry
	logic [11:0]       x0_q;
	logic [11:0]       y0_q;
	logic [SPAN_W-1:0] span_q;
	logic [HGT_W-1:0]  rows_q;
	logic [ROW_W-1:0]  sy_q;
	logic [SX_W-1:0]   sh_q;
	logic [HGT_W-1:0]  row_q;
	logic [31:0]       acc_q;

	// row in flight while the font read completes
	logic        s1_vld_q;
	logic [31:0] addr_s1;
	logic        last_s1;

	logic              out_vld_q;
	logic [31:0]       out_addr_q;
	logic [15:0]       out_mask_q;
	logic [SPAN_W-1:0] out_span_q;
	logic [31:0]       out_color_q;
	logic              out_last_q;

	// clip arithmetic
	logic [4:0]         cw;
	logic [5:0]         chh;
	logic [2:0]         bpp;
	logic signed [14:0] dx, dy, dx2, dy2, cr1, cb1, cl, ct;
	logic signed [14:0] x0, y0, x1, y1, sx, sy;
	logic               ch_ok, empty;

	// shared multiply-add
	logic [11:0] mul_a;
	logic [15:0] mul_b;
	logic [27:0] prod;
	logic [31:0] mac;

	logic                  adv;
	logic                  issue;
	logic [ROW_W-1:0]      line;
	logic [ROW_BITS_W-1:0] rev;
	logic [ROW_BITS_W-1:0] shifted;
	logic [ROW_BITS_W-1:0] span_mask;

	always_comb begin
		cw = cfg.glyph_width;
		if (cfg.glyph_width == 5'd0) begin
			cw = 5'd1;
		end else if (int'(cfg.glyph_width) > MAX_GLYPH_WIDTH) begin
			cw = 5'(MAX_GLYPH_WIDTH);
		end
		chh = cfg.glyph_height;
		if (cfg.glyph_height == 6'd0) begin
			chh = 6'd1;
		end else if (int'(cfg.glyph_height) > MAX_GLYPH_HEIGHT) begin
			chh = 6'(MAX_GLYPH_HEIGHT);
		end
		bpp = cfg.bytes_per_pixel;
		if (cfg.bytes_per_pixel == 3'd0) begin
			bpp = 3'd1;
		end else if (cfg.bytes_per_pixel > 3'd4) begin
			bpp = 3'd4;
		end
	end

	always_comb begin
		dx  = 15'(pos_x_q);
		dy  = 15'(pos_y_q);
		dx2 = dx + signed'({10'd0, cw});
		dy2 = dy + signed'({9'd0, chh});
		cl  = signed'({3'd0, cfg.clip_left});
		ct  = signed'({3'd0, cfg.clip_top});
		cr1 = signed'({3'd0, cfg.clip_right}) + 15'sd1;
		cb1 = signed'({3'd0, cfg.clip_bottom}) + 15'sd1;
		x0  = (dx < cl) ? cl : dx;
		y0  = (dy < ct) ? ct : dy;
		x1  = (dx2 > cr1) ? cr1 : dx2;
		y1  = (dy2 > cb1) ? cb1 : dy2;
		sx  = x0 - dx;
		sy  = y0 - dy;
		ch_ok = int'(ch_q) < NUM_CHARS;
		empty = !ch_ok || (dx >= cr1) || (dy >= cb1) || (x1 <= x0) || (y1 <= y0);
	end

	always_comb begin
		case (state_q)
			ST_MULX: begin
				mul_a = x0_q;
				mul_b = {13'd0, bpp};
			end
			ST_MULY: begin
				mul_a = y0_q;
				mul_b = cfg.line_pitch;
			end
			default: begin
				mul_a = 12'd1;
				mul_b = cfg.line_pitch;
			end
		endcase
		prod = mul_a * mul_b;
		mac  = acc_q + {4'd0, prod};
	end

	assign adv   = !out_vld_q || res.ready;
	assign issue = (state_q == ST_ROWS) && adv && (row_q < rows_q);
	assign line  = ROW_W'(HGT_W'(sy_q) + row_q);

	always_comb begin
		font_req.wr_en = (state_q == ST_IDLE) && req.valid && (req.req_type == REQ_LOAD)
			&& (int'(req.char_code) < NUM_CHARS) && (int'(req.row_index) < MAX_GLYPH_HEIGHT);
		font_req.wr_addr = FONT_AW'(int'(req.char_code) * MAX_GLYPH_HEIGHT)
			+ FONT_AW'(req.row_index);
		font_req.wr_data = req.row_bits;
		font_req.rd_en   = issue;
		font_req.rd_addr = FONT_AW'(int'(ch_q) * MAX_GLYPH_HEIGHT) + FONT_AW'(line);
	end

	// leftmost visible glyph pixel lands on mask bit 0
	always_comb begin
		for (int i = 0; i < ROW_BITS_W; i++) begin
			rev[i] = rd_data[ROW_BITS_W-1-i];
		end
		shifted   = rev >> sh_q;
		span_mask = ROW_BITS_W'(((ROW_BITS_W+1)'(1) << span_q) - (ROW_BITS_W+1)'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			s1_vld_q    <= 1'b0;
			out_vld_q   <= 1'b0;
			row_q       <= '0;
			out_addr_q  <= '0;
			out_mask_q  <= '0;
			out_span_q  <= '0;
			out_color_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (adv) begin
				out_vld_q <= s1_vld_q;
				if (s1_vld_q) begin
					out_addr_q  <= addr_s1;
					out_mask_q  <= shifted & span_mask;
					out_span_q  <= span_q;
					out_color_q <= color_q;
					out_last_q  <= last_s1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid && req.req_type == REQ_DRAW) begin
						state_q <= ST_CLIP;
					end
				end
				ST_CLIP: begin
					state_q <= empty ? ST_IDLE : ST_MULX;
				end
				ST_MULX: begin
					state_q <= ST_MULY;
				end
				ST_MULY: begin
					row_q   <= '0;
					state_q <= ST_ROWS;
				end
				ST_ROWS: begin
					if (adv) begin
						s1_vld_q <= issue;
						if (issue) begin
							row_q <= row_q + HGT_W'(1);
						end
					end
					if (row_q == rows_q && !s1_vld_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			ch_q    <= req.char_code;
			pos_x_q <= req.pos_x;
			pos_y_q <= req.pos_y;
			color_q <= req.pixel_color;
		end
		if (state_q == ST_CLIP) begin
			x0_q   <= x0[11:0];
			y0_q   <= y0[11:0];
			span_q <= SPAN_W'(x1 - x0);
			rows_q <= HGT_W'(y1 - y0);
			sy_q   <= ROW_W'(sy);
			sh_q   <= SX_W'(15'(ROW_BITS_W) - signed'({10'd0, cw}) + sx);
			acc_q  <= '0;
		end
		if (state_q == ST_MULX || state_q == ST_MULY || issue) begin
			acc_q <= mac;
		end
		if (issue) begin
			addr_s1 <= acc_q;
			last_s1 <= (row_q == rows_q - HGT_W'(1));
		end
	end

	assign req.ready       = (state_q == ST_IDLE);
	assign res.valid       = out_vld_q;
	assign res.row_address = out_addr_q;
	assign res.pixel_mask  = out_mask_q;
	assign res.span_length = out_span_q;
	assign res.out_color   = out_color_q;
	assign res.last_row    = out_last_q;

	ap_ready_drained: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !s1_vld_q)
		else $error("input ready while a row is still in flight");

	ap_span_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.span_length != 5'd0
			&& int'(res.span_length) <= MAX_GLYPH_WIDTH))
		else $error("result span out of range");

	ap_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		font_req.wr_en |-> !font_req.rd_en)
		else $error("font load during a row read");

	ap_last_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.last_row) |-> !s1_vld_q)
		else $error("rows remain behind the final row");

	ap_issue_count: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> (row_q <= rows_q))
		else $error("more rows issued than visible");

endmodule
